[hw/rtl/jssf_pkg.sv]
// jssf_pkg: shared types and constants for the jpeg scan start finder
// beat payload structs, marker codes and result status codes
// no dependencies
`default_nettype none

package jssf_pkg;

   localparam int POS_WIDTH_DEFAULT = 32;
   localparam int OCTET_W           = 8;
   localparam int LEN_FIELD_BYTES   = 2;
   localparam int CSR_WIDTH         = 32;
   localparam int OUT_POS_WIDTH     = 32;

   localparam logic [OCTET_W-1:0] MARK_PREFIX = 8'hFF;
   localparam logic [OCTET_W-1:0] MARK_SOI    = 8'hD8;
   localparam logic [OCTET_W-1:0] MARK_EOI    = 8'hD9;
   localparam logic [OCTET_W-1:0] MARK_SOS    = 8'hDA;

   typedef enum logic [1:0] {
      ST_FOUND      = 2'd0,
      ST_NO_PREFIX  = 2'd1,
      ST_OUT_OF_BUF = 2'd2,
      ST_BAD_LEN    = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      PH_PREFIX = 5'b00001,
      PH_CODE   = 5'b00010,
      PH_LEN_HI = 5'b00100,
      PH_LEN_LO = 5'b01000,
      PH_SKIP   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [OCTET_W-1:0] data_byte;
      logic               first_byte;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [OUT_POS_WIDTH-1:0] compress_pos;
   } rsp_type;

endpackage

`default_nettype wire

[hw/rtl/jpeg_scan_start_finder_unit.sv]
// jpeg_scan_start_finder_unit: walks jpeg marker segments one byte per beat
// and reports where the first scan's entropy-coded data begins
// depends on jssf_pkg
//
// One file byte enters per req beat and the block accepts a byte in every cycle
// while the result register is free or being drained. Each byte updates the
// marker-walk state in the cycle it is accepted; a search's result (status and
// compress_pos) is registered; it is on rsp next cycle and stays until taken.
// A first_byte beat restarts the search at offset zero; after a result, bytes
// without first_byte are dropped without a response. The user must write
// buffer_size through the always-ready csr port only while the block is idle;
// the block does not enforce this. Positions are POS_WIDTH bits and saturate.
`default_nettype none

module jpeg_scan_start_finder_unit
   import jssf_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_WIDTH-1:0] csr_data,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_payload
);

   localparam int CMP_W = ((POS_WIDTH + 3) > (CSR_WIDTH + 1)) ? (POS_WIDTH + 3)
                                                              : (CSR_WIDTH + 1);
   localparam int EXT_W = (POS_WIDTH > OUT_POS_WIDTH) ? POS_WIDTH : OUT_POS_WIDTH;

   logic [CSR_WIDTH-1:0]  buffer_size_ff;
   phase_type             phase_ff, phase_in;
   logic [POS_WIDTH-1:0]  pos_ff, pos_in;
   logic [OCTET_W-1:0]    code_ff, code_in;
   logic [OCTET_W-1:0]    len_hi_ff, len_hi_in;
   logic [POS_WIDTH-1:0]  skip_ff, skip_in;
   logic                  done_ff, done_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  req_fire;
   logic                  rsp_load;
   logic                  done_eff;
   phase_type             ph_eff;
   phase_type             ph_work;
   logic [POS_WIDTH-1:0]  pos_eff;
   logic [CMP_W-1:0]      buf_ext, pos_ext, pos_max_ext, two_ext;
   logic [CMP_W-1:0]      sum_p1, sum_p3, sum_tgt;
   logic [POS_WIDTH-1:0]  pos_p1, pos_p3, start_pos, target;
   logic [2*OCTET_W-1:0]  seg_len;
   logic                  room_pos, room_p1, over_p3, room_tgt;
   logic [EXT_W-1:0]      target_ext;
   logic [OUT_POS_WIDTH-1:0] target_out;
   logic [OCTET_W-1:0]    b;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign b = req_payload.data_byte;

   // restart applied ahead of the byte's own work
   assign done_eff = req_payload.first_byte ? 1'b0 : done_ff;
   assign ph_eff   = req_payload.first_byte ? PH_PREFIX : phase_ff;
   assign pos_eff  = req_payload.first_byte ? '0 : pos_ff;
   assign ph_work  = (ph_eff == PH_SKIP && pos_eff == skip_ff) ? PH_PREFIX : ph_eff;

   // saturating position arithmetic
   assign buf_ext     = CMP_W'(buffer_size_ff);
   assign pos_ext     = CMP_W'(pos_eff);
   assign pos_max_ext = CMP_W'({POS_WIDTH{1'b1}});
   assign two_ext     = CMP_W'(LEN_FIELD_BYTES);
   assign sum_p1 = pos_ext + CMP_W'(1);
   assign sum_p3 = pos_ext + CMP_W'(3);
   assign pos_p1 = (sum_p1 > pos_max_ext) ? {POS_WIDTH{1'b1}} : sum_p1[POS_WIDTH-1:0];
   assign pos_p3 = (sum_p3 > pos_max_ext) ? {POS_WIDTH{1'b1}} : sum_p3[POS_WIDTH-1:0];

   assign seg_len   = {len_hi_ff, b};
   assign start_pos = (pos_eff == '0) ? '0 : pos_eff - POS_WIDTH'(1);
   assign sum_tgt   = CMP_W'(start_pos) + CMP_W'(seg_len);
   assign target = (sum_tgt > pos_max_ext) ? {POS_WIDTH{1'b1}} : sum_tgt[POS_WIDTH-1:0];

   assign room_pos = buf_ext > (pos_ext + two_ext);
   assign room_p1  = buf_ext > (CMP_W'(pos_p1) + two_ext);
   assign over_p3  = CMP_W'(pos_p3) > buf_ext;
   assign room_tgt = buf_ext > (CMP_W'(target) + two_ext);

   assign target_ext = EXT_W'(target);
   assign target_out = (target_ext > EXT_W'({OUT_POS_WIDTH{1'b1}}))
                       ? {OUT_POS_WIDTH{1'b1}} : target_ext[OUT_POS_WIDTH-1:0];

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      code_in   = code_ff;
      len_hi_in = len_hi_ff;
      skip_in   = skip_ff;
      done_in   = done_ff;
      rsp_load  = 1'b0;
      rsp_in.status       = ST_FOUND;
      rsp_in.compress_pos = '0;
      if (req_fire) begin
         phase_in = ph_eff;
         pos_in   = pos_eff;
         done_in  = done_eff;
         if (!done_eff) begin
            pos_in = pos_p1;
            unique case (ph_work)
               PH_PREFIX: begin
                  if (!room_pos) begin
                     rsp_load      = 1'b1;
                     rsp_in.status = ST_OUT_OF_BUF;
                  end else if (b != MARK_PREFIX) begin
                     rsp_load      = 1'b1;
                     rsp_in.status = ST_NO_PREFIX;
                  end else begin
                     phase_in = PH_CODE;
                  end
               end
               PH_CODE: begin
                  code_in = b;
                  if (b == MARK_SOI || b == MARK_EOI) begin
                     if (!room_p1) begin
                        rsp_load      = 1'b1;
                        rsp_in.status = ST_OUT_OF_BUF;
                     end else begin
                        phase_in = PH_PREFIX;
                     end
                  end else if (over_p3) begin
                     rsp_load      = 1'b1;
                     rsp_in.status = ST_OUT_OF_BUF;
                  end else begin
                     phase_in = PH_LEN_HI;
                  end
               end
               PH_LEN_HI: begin
                  len_hi_in = b;
                  phase_in  = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  if (seg_len < (2*OCTET_W)'(LEN_FIELD_BYTES)) begin
                     rsp_load      = 1'b1;
                     rsp_in.status = ST_BAD_LEN;
                  end else if (code_ff == MARK_SOS) begin
                     rsp_load            = 1'b1;
                     rsp_in.status       = ST_FOUND;
                     rsp_in.compress_pos = target_out;
                  end else if (!room_tgt) begin
                     rsp_load      = 1'b1;
                     rsp_in.status = ST_OUT_OF_BUF;
                  end else begin
                     skip_in  = target;
                     phase_in = PH_SKIP;
                  end
               end
               PH_SKIP: begin
               end
               default: begin
               end
            endcase
            if (rsp_load) begin
               done_in = 1'b1;
            end
         end
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff <= '0;
         phase_ff       <= PH_PREFIX;
         pos_ff         <= '0;
         code_ff        <= '0;
         len_hi_ff      <= '0;
         skip_ff        <= '0;
         done_ff        <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            buffer_size_ff <= csr_data;
         end
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         code_ff      <= code_in;
         len_hi_ff    <= len_hi_in;
         skip_ff      <= skip_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef ASSERT_OFF
   a_found_pos : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == ST_FOUND) |-> (rsp_payload.compress_pos >= 2))
      else $error("found result with offset below two");
   a_fail_pos : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != ST_FOUND) |-> (rsp_payload.compress_pos == '0))
      else $error("failed search with nonzero offset");
   a_idle_quiet : assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!done_ff || req_payload.first_byte))
      else $error("result while waiting for a first byte");
   a_done_after : assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> done_ff)
      else $error("search not closed after its result");
   a_load_free : assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrote an undelivered beat");
`endif

endmodule

`default_nettype wire

[sim/jpeg_scan_start_finder_unit_tb.sv]
// jpeg_scan_start_finder_unit_tb: self-checking bench for the jpeg scan start finder
// streams jpeg-like byte beats, tracks the marker walk itself and checks each result beat
// depends on jssf_pkg and jpeg_scan_start_finder_unit

module jpeg_scan_start_finder_unit_tb;
   import jssf_pkg::*;

   localparam logic [63:0] POS_MAX = (64'd1 << POS_WIDTH_DEFAULT) - 64'd1;
   localparam logic [7:0]  MARK_APP1 = 8'hE1;
   localparam logic [7:0]  MARK_DHT  = 8'hC4;
   localparam int          RANDOM_BEATS = 900;

   typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [31:0]  cfg_value;
      logic [7:0]   data;
      logic         first;
      logic         typed;
      status_type   status;
      logic [31:0]  pos;
   } dir_row_type;

   localparam dir_row_type DIR_TABLE [33] = '{
      '{ROW_CFG,  32'd0, 8'h00, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, MARK_PREFIX, 1'b1, 1'b1, ST_OUT_OF_BUF, 32'd0},
      '{ROW_BEAT, 32'd0, 8'h00, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_CFG,  32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, MARK_PREFIX, 1'b1, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, MARK_SOI, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, MARK_PREFIX, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, MARK_SOS, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, 8'h00, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, 8'h02, 1'b0, 1'b1, ST_FOUND, 32'd6},
      '{ROW_BEAT, 32'd0, 8'h00, 1'b1, 1'b1, ST_NO_PREFIX, 32'd0},
      '{ROW_BEAT, 32'd0, MARK_PREFIX, 1'b1, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, MARK_EOI, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, MARK_PREFIX, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, MARK_APP1, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, 8'h00, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, 8'h03, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, 8'hA5, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, MARK_PREFIX, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, MARK_SOS, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, 8'hFF, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, 8'hFF, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, MARK_PREFIX, 1'b1, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, MARK_DHT, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, MARK_PREFIX, 1'b1, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, MARK_SOS, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, 8'h00, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, 8'h01, 1'b0, 1'b1, ST_BAD_LEN, 32'd0},
      '{ROW_CFG,  32'd3, 8'h00, 1'b0, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, MARK_PREFIX, 1'b1, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, MARK_APP1, 1'b0, 1'b1, ST_OUT_OF_BUF, 32'd0},
      '{ROW_BEAT, 32'd0, MARK_PREFIX, 1'b1, 1'b0, ST_FOUND, 32'd0},
      '{ROW_BEAT, 32'd0, MARK_SOI, 1'b0, 1'b1, ST_OUT_OF_BUF, 32'd0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_WIDTH-1:0] csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_payload;

   // marker walk tracked by the bench
   logic [31:0] buf_bytes = '0;
   phase_type   scan_phase = PH_PREFIX;
   logic [63:0] scan_pos = '0;
   logic [7:0]  scan_code = '0;
   logic [7:0]  scan_len_hi = '0;
   logic [63:0] scan_skip_to = '0;
   bit          scan_idle = 1'b1;

   rsp_type     expected_results[$];
   req_type     file_beats[$];
   rsp_type     want_rsp;
   int          mismatch_count = 0;
   int          sent_beats = 0;
   int          burst_left = 0;
   int          stall_mode = 0;
   int          stall_left = 0;

   jpeg_scan_start_finder_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [63:0] sat_pos_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > POS_MAX) ? POS_MAX : s;
   endfunction

   function automatic bit has_room(input logic [63:0] p);
      return {32'd0, buf_bytes} > p + 64'd2;
   endfunction

   function automatic rsp_type end_search(input status_type st, input logic [63:0] p);
      rsp_type r;
      r.status = st;
      r.compress_pos = (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
      scan_idle = 1'b1;
      return r;
   endfunction

   function automatic void predict_scan_result(input req_type beat,
                                               output bit got, output rsp_type r);
      logic [63:0] pos;
      logic [63:0] len;
      logic [63:0] start;
      logic [63:0] target;
      phase_type   ph;
      got = 1'b0;
      r = '0;
      if (beat.first_byte) begin
         scan_idle = 1'b0;
         scan_phase = PH_PREFIX;
         scan_pos = '0;
      end
      if (!scan_idle) begin
         pos = scan_pos;
         ph = scan_phase;
         if (ph == PH_SKIP && pos == scan_skip_to) ph = PH_PREFIX;
         case (ph)
            PH_PREFIX: begin
               if (!has_room(pos)) begin
                  r = end_search(ST_OUT_OF_BUF, 64'd0);
                  got = 1'b1;
               end else if (beat.data_byte != MARK_PREFIX) begin
                  r = end_search(ST_NO_PREFIX, 64'd0);
                  got = 1'b1;
               end else begin
                  scan_phase = PH_CODE;
               end
            end
            PH_CODE: begin
               scan_code = beat.data_byte;
               if (beat.data_byte == MARK_SOI || beat.data_byte == MARK_EOI) begin
                  if (!has_room(sat_pos_add(pos, 64'd1))) begin
                     r = end_search(ST_OUT_OF_BUF, 64'd0);
                     got = 1'b1;
                  end else begin
                     scan_phase = PH_PREFIX;
                  end
               end else if (sat_pos_add(pos, 64'd3) > {32'd0, buf_bytes}) begin
                  r = end_search(ST_OUT_OF_BUF, 64'd0);
                  got = 1'b1;
               end else begin
                  scan_phase = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               scan_len_hi = beat.data_byte;
               scan_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               len = {48'd0, scan_len_hi, beat.data_byte};
               start = (pos > 0) ? pos - 64'd1 : 64'd0;
               target = sat_pos_add(start, len);
               got = 1'b1;
               if (len < 64'd2) begin
                  r = end_search(ST_BAD_LEN, 64'd0);
               end else if (scan_code == MARK_SOS) begin
                  r = end_search(ST_FOUND, target);
               end else if (!has_room(target)) begin
                  r = end_search(ST_OUT_OF_BUF, 64'd0);
               end else begin
                  got = 1'b0;
                  scan_skip_to = target;
                  scan_phase = PH_SKIP;
               end
            end
            default: ;
         endcase
         scan_pos = sat_pos_add(pos, 64'd1);
      end
   endfunction

   // sender: bursts of beats with random gaps in between
   task automatic send_beat(input req_type beat, input bit typed, input rsp_type typed_rsp);
      int      gap_len;
      bit      got;
      rsp_type r;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap_len != 0) begin
            req_valid <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (!req_ready);
      predict_scan_result(beat, got, r);
      sent_beats++;
      if (typed) expected_results.push_back(typed_rsp);
      else if (got) expected_results.push_back(r);
   endtask

   // drain all results, let the block settle, then write buffer_size
   task automatic write_buffer_size(input logic [31:0] value);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      buf_bytes = value;
      csr_valid <= 1'b0;
   endtask

   function automatic void add_beat(input logic [7:0] d, input logic f);
      file_beats.push_back('{data_byte: d, first_byte: f});
   endfunction

   // one file: mostly well-formed marker chains ending in sos, some noise and damage
   task automatic build_file();
      int          nseg;
      int          cut;
      logic [7:0]  code;
      logic [15:0] len;
      file_beats.delete();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6))
            add_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
         add_beat(($urandom_range(0, 14) == 0) ? 8'($urandom_range(0, 254)) : MARK_PREFIX, 1'b1);
         nseg = $urandom_range(0, 4);
         repeat (nseg) begin
            add_beat(($urandom_range(0, 24) == 0) ? 8'($urandom_range(0, 254)) : MARK_PREFIX,
                     1'b0);
            if ($urandom_range(0, 3) == 0) begin
               add_beat($urandom_range(0, 1) ? MARK_SOI : MARK_EOI, 1'b0);
            end else begin
               code = 8'($urandom_range(0, 255));
               if (code == MARK_SOI || code == MARK_EOI || code == MARK_SOS) code = code ^ 8'h10;
               case ($urandom_range(0, 15))
                  0: len = 16'($urandom_range(0, 1));
                  1: len = 16'($urandom_range(9, 40));
                  default: len = 16'($urandom_range(2, 8));
               endcase
               add_beat(code, 1'b0);
               add_beat(len[15:8], 1'b0);
               add_beat(len[7:0], 1'b0);
               if (len >= 2) repeat (len - 2) add_beat(8'($urandom_range(0, 255)), 1'b0);
            end
         end
         case ($urandom_range(0, 11))
            0: len = 16'($urandom_range(0, 1));
            1: len = 16'hFFFF;
            2: len = 16'($urandom_range(0, 65535));
            default: len = 16'($urandom_range(2, 600));
         endcase
         add_beat(MARK_PREFIX, 1'b0);
         add_beat(MARK_SOS, 1'b0);
         add_beat(len[15:8], 1'b0);
         add_beat(len[7:0], 1'b0);
      end
      if ($urandom_range(0, 9) == 0) begin
         cut = $urandom_range(1, file_beats.size());
         while (file_beats.size() > cut) void'(file_beats.pop_back());
      end
   endtask

   // receiver: stretches of always-ready, coin-flip and mostly-stalled
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(8, 64);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t unexpected result beat: expected none, actual status %0d pos %0d",
                     $time, rsp_payload.status, rsp_payload.compress_pos);
            mismatch_count++;
         end else begin
            want_rsp = expected_results.pop_front();
            if (rsp_payload.status !== want_rsp.status) begin
               $display("%0t status mismatch: expected %0d, actual %0d",
                        $time, want_rsp.status, rsp_payload.status);
               mismatch_count++;
            end
            if (rsp_payload.compress_pos !== want_rsp.compress_pos) begin
               $display("%0t compress_pos mismatch: expected %0d, actual %0d",
                        $time, want_rsp.compress_pos, rsp_payload.compress_pos);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int          random_start;
      int          phase_start;
      int          phase_files;
      logic [31:0] size_pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIR_TABLE[i]) begin
         if (DIR_TABLE[i].kind == ROW_CFG) begin
            write_buffer_size(DIR_TABLE[i].cfg_value);
         end else begin
            send_beat('{data_byte: DIR_TABLE[i].data, first_byte: DIR_TABLE[i].first},
                      DIR_TABLE[i].typed,
                      '{status: DIR_TABLE[i].status, compress_pos: DIR_TABLE[i].pos});
         end
      end

      random_start = sent_beats;
      while (sent_beats - random_start < RANDOM_BEATS) begin
         case ($urandom_range(0, 5))
            0: size_pick = 32'hFFFF_FFFF;
            1: size_pick = 32'd0;
            2: size_pick = $urandom_range(0, 12);
            3: size_pick = $urandom_range(13, 80);
            4: size_pick = $urandom_range(81, 2000);
            default: size_pick = $urandom;
         endcase
         write_buffer_size(size_pick);
         phase_start = sent_beats;
         phase_files = 0;
         while (sent_beats - phase_start < 120 && phase_files < 25) begin
            build_file();
            foreach (file_beats[k]) send_beat(file_beats[k], 1'b0, '0);
            phase_files++;
         end
      end

      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("jpeg_scan_start_finder_unit_tb OK");
      end else begin
         $display("jpeg_scan_start_finder_unit_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("jpeg_scan_start_finder_unit_tb NOT OK");
      $finish;
   end

endmodule
